// ----- hw/rtl/b64_pkg.sv -----
// Shared types, constants and alphabet functions for the Base64 stream codec.
package b64_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned JOB_SLOTS   = 4;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [7:0] CHAR_PAD    = 8'h3D;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] MIN_WIDTH   = 8'd4;
    localparam logic [7:0] RESET_WIDTH = 8'd76;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_MODE       = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } reg_idx_t;

    // One unit of work for the output side: up to four bytes, plus line handling.
    typedef struct packed
    {
        logic [JOB_SLOTS-1:0][7:0] data;
        logic [2:0]                cnt;
        logic                      enc;
        logic                      last_nl;
    } job_t;

    // Control from the register block to both halves.
    typedef struct packed
    {
        mode_t      mode;
        logic [7:0] width;
        logic       clear;
    } ctl_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] c;
        v8 = {2'b00, v};
        priority if (v < 6'd26)
        begin
            c = v8 + 8'd65;
        end
        else if (v < 6'd52)
        begin
            c = v8 + 8'd71;
        end
        else if (v < 6'd62)
        begin
            c = v8 - 8'd4;
        end
        else if (v == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Returns {valid, sextet}; valid is low for anything outside the alphabet.
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'd0;
        ok = 1'b1;
        priority if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = c - 8'd65;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'd71;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c + 8'd4;
        end
        else if (c == 8'h2B)
        begin
            d = 8'd62;
        end
        else if (c == 8'h2F)
        begin
            d = 8'd63;
        end
        else
        begin
            ok = 1'b0;
        end
        return {ok, d[5:0]};
    endfunction

endpackage

// ----- hw/rtl/b64_in_if.sv -----
// Input word channel: one byte or character per word, with an end-of-stream mark.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- hw/rtl/b64_out_if.sv -----
// Output word channel: one result byte per word, with a run-end mark.
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

// ----- hw/rtl/b64_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface b64_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [b64_pkg::CFG_IDX_W-1:0]    index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/base64_codec_stream.sv -----
// Top level of the Base64 stream codec: registers, front, job queue and back.
//
// Base64 (standard alphabet, '=' padding) stream codec. Write register 0 (mode)
// to pick encode (0) or decode (1); the write also restarts the stream. Register 1
// sets the characters per encoded line (values below 4 act as 4). Each input word
// carries one byte plus is_last; the block answers with zero to six output words,
// and run_end marks the final word caused by that input. Encode turns three bytes
// into four characters, inserts a newline whenever the line fills, and on is_last
// flushes a padded partial group followed by a newline if the line is open.
// Decode skips anything outside the alphabet, counts '=' as zero and drops the
// bytes that a third or fourth place '=' covers; a partial group at is_last is
// dropped. Rate: the input side takes one word per cycle while the two-entry job
// queue has room; the output side delivers one word per cycle while out_ch is
// ready, so a full encode group yields four to six words (four characters plus
// newlines) and decode takes one character per cycle while the queue has room.
// A word's first result passes the queue slot, job and output registers.
// Configuration writes are taken every cycle and belong to idle periods only.
module base64_codec_stream
(
    input  logic     clk,
    input  logic     rst_n,
    b64_in_if.sink   in_ch,
    b64_out_if.source out_ch,
    b64_cfg_if.sink  cfg
);

    b64_pkg::mode_t mode_reg;
    logic [7:0]     line_width_reg;
    logic           cfg_wr;
    b64_pkg::ctl_t  ctl;

    b64_pkg::job_t  front_job;
    logic           front_push;
    b64_pkg::job_t  q_head;
    logic           q_not_full;
    logic           q_not_empty;
    logic           back_pop;

    // Register port never stalls.
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // Clamp narrow widths, and restart both halves on a mode write.
    assign ctl.mode  = mode_reg;
    assign ctl.width = (line_width_reg < b64_pkg::MIN_WIDTH) ? b64_pkg::MIN_WIDTH
                                                             : line_width_reg;
    assign ctl.clear = cfg_wr && (cfg.index == b64_pkg::REG_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= b64_pkg::MODE_ENCODE;
            line_width_reg <= b64_pkg::RESET_WIDTH;
        end
        else if (cfg_wr)
        begin
            if (cfg.index == b64_pkg::REG_MODE)
            begin
                mode_reg <= b64_pkg::mode_t'(cfg.data[0]);
            end
            else
            begin
                line_width_reg <= cfg.data;
            end
        end
    end

    // Front: classify each word and hand finished groups to the queue.
    b64_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .ctl      (ctl),
        .q_ready  (q_not_full),
        .job      (front_job),
        .job_push (front_push)
    );

    // Queue: lets the input keep flowing while the output side works off a group.
    b64_job_fifo u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .pop       (back_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // Back: one output word per cycle while the output is ready, with line breaks and run-end marking.
    b64_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .head    (q_head),
        .q_valid (q_not_empty),
        .pop     (back_pop),
        .out_ch  (out_ch)
    );

`ifndef SYNTHESIS
    a_width_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.width >= b64_pkg::MIN_WIDTH)
        else $error("effective line width below four");
`endif

endmodule

// ----- hw/rtl/b64_job_fifo.sv -----
// Short job queue between the classifying front and the emitting back.
module b64_job_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64_pkg::job_t   push_job,
    output logic            not_full,
    input  logic            pop,
    output b64_pkg::job_t   head,
    output logic            not_empty
);

    localparam int unsigned PW = b64_pkg::QUEUE_PTR_W;
    localparam int unsigned CW = b64_pkg::QUEUE_CNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(b64_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(b64_pkg::QUEUE_DEPTH);

    b64_pkg::job_t slot_reg [b64_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL_CNT))
        else $error("job queue written while full");
`endif

endmodule

// ----- hw/rtl/b64_front.sv -----
// Front half: accept input words, gather groups and build output jobs.
module b64_front
(
    input  logic            clk,
    input  logic            rst_n,
    b64_in_if.sink          in_ch,
    input  b64_pkg::ctl_t   ctl,
    input  logic            q_ready,
    output b64_pkg::job_t   job,
    output logic            job_push
);

    logic [17:0] gb_reg;
    logic [17:0] gb_next;
    logic [1:0]  gc_reg;
    logic [1:0]  gc_next;
    logic        pm_reg;
    logic        pm_next;

    logic        accept;
    logic [7:0]  b;
    logic [23:0] enc_bits;
    logic [6:0]  dec;
    logic        pad;
    logic        sym_ok;
    logic [5:0]  s;
    logic [23:0] dec_bits;
    logic [15:0] two;

    assign in_ch.ready = q_ready;
    assign accept      = in_ch.valid && q_ready;
    assign b           = in_ch.in_byte;
    assign enc_bits    = {gb_reg[15:0], b};
    assign two         = {gb_reg[7:0], b};
    assign dec         = b64_pkg::char_sextet(b);
    assign pad         = (b == b64_pkg::CHAR_PAD);
    assign sym_ok      = dec[6] || pad;
    assign s           = pad ? 6'd0 : dec[5:0];
    assign dec_bits    = {gb_reg[17:0], s};

    always_comb
    begin
        job     = '0;
        gb_next = gb_reg;
        gc_next = gc_reg;
        pm_next = pm_reg;
        if (ctl.mode == b64_pkg::MODE_ENCODE)
        begin
            job.enc     = 1'b1;
            job.last_nl = in_ch.is_last;
            unique case (gc_reg)
                2'd2:
                begin
                    job.data[0] = b64_pkg::sextet_char(enc_bits[23:18]);
                    job.data[1] = b64_pkg::sextet_char(enc_bits[17:12]);
                    job.data[2] = b64_pkg::sextet_char(enc_bits[11:6]);
                    job.data[3] = b64_pkg::sextet_char(enc_bits[5:0]);
                    job.cnt     = 3'd4;
                    gb_next     = '0;
                    gc_next     = 2'd0;
                end
                2'd1:
                begin
                    if (in_ch.is_last)
                    begin
                        job.data[0] = b64_pkg::sextet_char(two[15:10]);
                        job.data[1] = b64_pkg::sextet_char(two[9:4]);
                        job.data[2] = b64_pkg::sextet_char({two[3:0], 2'b00});
                        job.data[3] = b64_pkg::CHAR_PAD;
                        job.cnt     = 3'd4;
                    end
                    gb_next = enc_bits[17:0];
                    gc_next = 2'd2;
                end
                2'd0, 2'd3:
                begin
                    if (in_ch.is_last)
                    begin
                        job.data[0] = b64_pkg::sextet_char(b[7:2]);
                        job.data[1] = b64_pkg::sextet_char({b[1:0], 4'b0000});
                        job.data[2] = b64_pkg::CHAR_PAD;
                        job.data[3] = b64_pkg::CHAR_PAD;
                        job.cnt     = 3'd4;
                    end
                    gb_next = enc_bits[17:0];
                    gc_next = 2'd1;
                end
            endcase
        end
        else if (sym_ok)
        begin
            if (gc_reg == 2'd3)
            begin
                // A pad in third place drops the middle byte, in fourth the last.
                job.data[0] = dec_bits[23:16];
                job.data[1] = pm_reg ? dec_bits[7:0] : dec_bits[15:8];
                job.data[2] = dec_bits[7:0];
                job.cnt     = 3'd1 + {2'b00, !pm_reg} + {2'b00, !pad};
                gb_next     = '0;
                gc_next     = 2'd0;
                pm_next     = 1'b0;
            end
            else
            begin
                gb_next = dec_bits[17:0];
                gc_next = gc_reg + 2'd1;
                pm_next = pm_reg || (pad && (gc_reg == 2'd2));
            end
        end
        if (in_ch.is_last)
        begin
            gb_next = '0;
            gc_next = 2'd0;
            pm_next = 1'b0;
        end
    end

    assign job_push = accept && ((job.cnt != 3'd0) || job.last_nl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gb_reg <= '0;
            gc_reg <= 2'd0;
            pm_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            gb_reg <= '0;
            gc_reg <= 2'd0;
            pm_reg <= 1'b0;
        end
        else if (accept)
        begin
            gb_reg <= gb_next;
            gc_reg <= gc_next;
            pm_reg <= pm_next;
        end
    end

`ifndef SYNTHESIS
    a_enc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mode == b64_pkg::MODE_ENCODE) |-> (gc_reg != 2'd3))
        else $error("encode group count reached three without flushing");
    a_pad_mark: assert property (@(posedge clk) disable iff (!rst_n)
        pm_reg |-> (gc_reg == 2'd3))
        else $error("third-place pad mark set outside the fourth slot");
`endif

endmodule

// ----- hw/rtl/b64_back.sv -----
// Back half: walk jobs one word per cycle unless stalled, add newlines, drive the output register.
module b64_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  b64_pkg::ctl_t   ctl,
    input  b64_pkg::job_t   head,
    input  logic            q_valid,
    output logic            pop,
    b64_out_if.source       out_ch
);

    b64_pkg::job_t job_reg;
    logic          job_vld_reg;
    logic          job_vld_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          nl_pend_reg;
    logic          nl_pend_next;
    logic [7:0]    lc_reg;
    logic [7:0]    lc_next;
    logic          out_vld_reg;
    logic [7:0]    out_byte_reg;
    logic          out_end_reg;

    logic          can_emit;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_end;
    logic          done;
    logic [8:0]    lc1;
    logic          nl_after;
    logic          at_end;
    logic          last_char;

    assign out_ch.valid    = out_vld_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.run_end  = out_end_reg;

    assign can_emit  = !out_vld_reg || out_ch.ready;
    assign lc1       = {1'b0, lc_reg} + 9'd1;
    assign nl_after  = job_reg.enc && (lc1 >= {1'b0, ctl.width});
    assign at_end    = (idx_reg == job_reg.cnt);
    assign last_char = (idx_reg == (job_reg.cnt - 3'd1));

    always_comb
    begin
        emit         = 1'b0;
        emit_byte    = b64_pkg::CHAR_NL;
        emit_end     = 1'b0;
        done         = 1'b0;
        lc_next      = lc_reg;
        nl_pend_next = nl_pend_reg;
        idx_next     = idx_reg;
        if (job_vld_reg && can_emit)
        begin
            priority if (nl_pend_reg)
            begin
                emit         = 1'b1;
                emit_end     = at_end;
                done         = at_end;
                lc_next      = 8'd0;
                nl_pend_next = 1'b0;
            end
            else if (!at_end)
            begin
                emit      = 1'b1;
                emit_byte = job_reg.data[idx_reg[1:0]];
                idx_next  = idx_reg + 3'd1;
                if (job_reg.enc)
                begin
                    lc_next      = nl_after ? 8'd0 : lc1[7:0];
                    nl_pend_next = nl_after;
                end
                emit_end = last_char && !nl_after && !job_reg.last_nl;
                done     = emit_end;
            end
            else
            begin
                // Closing newline only if the line holds characters.
                emit     = (lc_reg != 8'd0);
                emit_end = 1'b1;
                done     = 1'b1;
                lc_next  = 8'd0;
            end
        end
    end

    assign pop          = (!job_vld_reg || done) && q_valid;
    assign job_vld_next = pop ? 1'b1 : (done ? 1'b0 : job_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_vld_reg <= 1'b0;
            idx_reg     <= 3'd0;
            nl_pend_reg <= 1'b0;
            lc_reg      <= 8'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            job_vld_reg <= job_vld_next;
            idx_reg     <= pop ? 3'd0 : idx_next;
            nl_pend_reg <= nl_pend_next;
            lc_reg      <= ctl.clear ? 8'd0 : lc_next;
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg  <= emit_end;
        end
    end

`ifndef SYNTHESIS
    a_nl_owner: assert property (@(posedge clk) disable iff (!rst_n)
        nl_pend_reg |-> (job_vld_reg && job_reg.enc))
        else $error("pending newline without an encode job");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_vld_reg |-> (idx_reg <= job_reg.cnt))
        else $error("job slot index ran past the job length");
`endif

endmodule
